/* src/coalescing_command_queue_unit_macros.svh */
// Assertion helpers for the queue RTL.
`ifndef COALESCING_COMMAND_QUEUE_UNIT_MACROS_SVH
`define COALESCING_COMMAND_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CCQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ccq_pkg.sv */
package ccq_pkg;

  // Field widths
  localparam int KEY_W  = 8;
  localparam int PAY_W  = 16;
  localparam int MODE_W = 2;
  localparam int STAT_W = 3;
  localparam int FILL_W = 5;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_QUEUED    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_COALESCED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_POPPED    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_FLUSHED   = 3'd5;

  // Cell operations
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t OP_HOLD = 3'd0;  // keep contents
  localparam cell_op_t OP_SHL  = 3'd1;  // take right neighbor (head leaves)
  localparam cell_op_t OP_SHR  = 3'd2;  // take left neighbor (insert at head)
  localparam cell_op_t OP_DEL  = 3'd3;  // close up over the first matching entry
  localparam cell_op_t OP_APP  = 3'd4;  // first empty cell takes the new entry

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    cell_op_t         op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } cell_ctrl_t;

endpackage

/* src/ccq_cell.sv */
module ccq_cell (
  input  logic                clk,
  input  logic                rst,
  input  ccq_pkg::cell_ctrl_t ctrl,
  input  ccq_pkg::entry_t     left_entry,
  input  ccq_pkg::entry_t     right_entry,
  input  logic                hit_in,
  output ccq_pkg::entry_t     entry,
  output logic                hit_out
);
  import ccq_pkg::*;

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;
  entry_t           entry_next;
  logic             match;

  assign entry = '{valid: valid, key: key, payload: payload};

  // Match chain: set from the first valid entry holding the key onward
  assign match   = valid && (key == ctrl.key);
  assign hit_out = hit_in || match;

  // Next contents per operation
  always_comb begin
    entry_next = entry;
    unique case (ctrl.op)
      OP_HOLD: entry_next = entry;
      OP_SHL:  entry_next = right_entry;
      OP_SHR:  entry_next = left_entry;
      OP_DEL: begin
        if (hit_out) entry_next = right_entry;
      end
      OP_APP: begin
        if (!valid && left_entry.valid) begin
          entry_next = '{valid: 1'b1, key: ctrl.key, payload: ctrl.payload};
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= entry_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    key     <= entry_next.key;
    payload <= entry_next.payload;
  end

endmodule

/* src/coalescing_command_queue_unit.sv */
// Coalescing command queue: a DEPTH-entry FIFO held in a row of cells, head
// in cell 0. A normal push removes every queued entry with the same key, one
// per cycle, then appends at the tail (coalesced if any were removed, else
// queued) or, with nothing removed and no room, reports dropped. A recovery
// push inserts at the head in the cycle it is accepted, or is dropped when
// full. A pop removes the head in the cycle it is accepted. Flush sends one
// transfer per entry, head first, one per cycle while the output is taken,
// with tlast on the final one; on an empty queue pop and flush give one empty
// result. The next command is taken after the previous one's final result,
// once the output register is free or being drained. Mode 3 is ignored.
module coalescing_command_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Command channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // target_key[7:0], payload_handle[23:8]
  input  logic [2:0]  s_tuser,   // mode[1:0], is_recovery[2]
  // Result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_key[7:0], out_payload[23:8], fill_level[28:24]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast
);
  import ccq_pkg::*;

  `include "coalescing_command_queue_unit_macros.svh"

  localparam int OW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DEL   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]        state, state_next;
  logic [OW-1:0]     occ, occ_next;
  logic              removed, removed_next;
  logic [KEY_W-1:0]  req_key;
  logic [PAY_W-1:0]  req_payload;

  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [KEY_W-1:0]  out_key;
  logic [PAY_W-1:0]  out_payload;
  logic [FILL_W-1:0] out_fill;
  logic              out_last;

  logic [MODE_W-1:0] in_mode;
  logic [KEY_W-1:0]  in_key;
  logic [PAY_W-1:0]  in_payload;
  logic              in_rec;
  logic              in_fire;
  logic              out_free;
  logic              full, empty;

  cell_ctrl_t        ctrl;
  entry_t            cells [DEPTH];
  logic [DEPTH:0]    hit;
  logic [DEPTH-1:0]  valid_vec;
  entry_t            new_entry;
  logic              any_hit;

  logic              load;
  logic [STAT_W-1:0] res_status;
  logic [KEY_W-1:0]  res_key;
  logic [PAY_W-1:0]  res_payload;
  logic [OW-1:0]     res_occ;
  logic              res_last;

  // Port unpacking
  assign in_mode    = s_tuser[1:0];
  assign in_rec     = s_tuser[2];
  assign in_key     = s_tdata[7:0];
  assign in_payload = s_tdata[23:8];

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;
  assign full     = (occ == OW'(DEPTH));
  assign empty    = (occ == '0);

  // Cell row; cell 0 sees the incoming entry as its left neighbor
  assign new_entry = '{valid: 1'b1, key: ctrl.key, payload: ctrl.payload};
  assign hit[0]    = 1'b0;
  assign any_hit   = hit[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    if (i == 0) begin : g_head
      assign left_e = new_entry;
    end else begin : g_mid
      assign left_e = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cells[i+1];
    end
    ccq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_entry (left_e),
      .right_entry(right_e),
      .hit_in     (hit[i]),
      .entry      (cells[i]),
      .hit_out    (hit[i+1])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  // Sequencer
  always_comb begin
    state_next   = state;
    occ_next     = occ;
    removed_next = removed;
    ctrl.op      = OP_HOLD;
    ctrl.key     = req_key;
    ctrl.payload = req_payload;
    load         = 1'b0;
    res_status   = STAT_QUEUED;
    res_key      = '0;
    res_payload  = '0;
    res_occ      = occ;
    res_last     = 1'b1;
    unique case (state)
      S_IDLE: begin
        ctrl.key     = in_key;
        ctrl.payload = in_payload;
        if (in_fire) begin
          case (in_mode)
            MODE_PUSH: begin
              if (in_rec) begin
                load = 1'b1;
                if (full) begin
                  res_status = STAT_DROPPED;
                end else begin
                  ctrl.op    = OP_SHR;
                  occ_next   = occ + OW'(1);
                  res_occ    = occ + OW'(1);
                  res_status = STAT_QUEUED;
                end
              end else begin
                state_next   = S_DEL;
                removed_next = 1'b0;
              end
            end
            MODE_POP: begin
              load = 1'b1;
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                ctrl.op     = OP_SHL;
                res_status  = STAT_POPPED;
                res_key     = cells[0].key;
                res_payload = cells[0].payload;
                occ_next    = occ - OW'(1);
                res_occ     = occ - OW'(1);
              end
            end
            MODE_FLUSH: begin
              if (empty) begin
                load       = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                state_next = S_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEL: begin
        if (any_hit) begin
          ctrl.op      = OP_DEL;
          occ_next     = occ - OW'(1);
          removed_next = 1'b1;
        end else if (out_free) begin
          state_next = S_IDLE;
          load       = 1'b1;
          if (removed || !full) begin
            ctrl.op    = OP_APP;
            occ_next   = occ + OW'(1);
            res_occ    = occ + OW'(1);
            res_status = removed ? STAT_COALESCED : STAT_QUEUED;
          end else begin
            res_status = STAT_DROPPED;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          ctrl.op     = OP_SHL;
          load        = 1'b1;
          res_status  = STAT_FLUSHED;
          res_key     = cells[0].key;
          res_payload = cells[0].payload;
          occ_next    = occ - OW'(1);
          res_occ     = occ - OW'(1);
          res_last    = (occ == OW'(1));
          if (occ == OW'(1)) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      occ     <= '0;
      removed <= 1'b0;
    end else begin
      state   <= state_next;
      occ     <= occ_next;
      removed <= removed_next;
    end
  end

  // Held command fields, used by the normal push
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_key     <= in_key;
      req_payload <= in_payload;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status  <= res_status;
      out_key     <= res_key;
      out_payload <= res_payload;
      out_fill    <= FILL_W'(res_occ);
      out_last    <= res_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {3'b000, out_fill, out_payload, out_key};

  // Checks
  `CCQ_ASSERT_NOW(a_occ_bound, clk, rst, 1'b1, occ <= OW'(DEPTH),
                  "occupancy above depth")
  `CCQ_ASSERT_NOW(a_occ_count, clk, rst, 1'b1, $countones(valid_vec) == int'(occ),
                  "occupancy and valid cells disagree")
  `CCQ_ASSERT_NOW(a_packed, clk, rst, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0,
                  "hole in cell row")
  `CCQ_ASSERT_NOW(a_flush_last, clk, rst,
                  out_valid && (out_status == STAT_FLUSHED) && out_last,
                  out_fill == '0, "flush last mismatch")
  `CCQ_ASSERT_NEXT(a_del_shrinks, clk, rst, (state == S_DEL) && any_hit,
                   occ == $past(occ) - OW'(1), "removal did not shrink queue")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ccq_pkg::*;

  localparam int QDEPTH = 16;
  // Mode 3 has no meaning; the queue must ignore it
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // Cycles with no transfer on either side before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  // Quiet cycles after the last expected result, to catch stray transfers
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [FILL_W-1:0] fill;
    logic              last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // target_key[7:0], payload_handle[23:8]
  logic [2:0]  s_tuser;   // mode[1:0], is_recovery[2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // out_key[7:0], out_payload[23:8], fill_level[28:24]
  logic [2:0]  m_tuser;   // status[2:0]
  logic        m_tlast;

  // Shadow copy of the queue contents, head at index 0
  logic [KEY_W-1:0] held_key [QDEPTH];
  logic [PAY_W-1:0] held_pay [QDEPTH];
  int               held_count = 0;
  result_t          pending_results [$];

  int errors = 0;
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;

  coalescing_command_queue_unit #(.DEPTH(QDEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void add_result(logic [STAT_W-1:0] status, logic [KEY_W-1:0] key,
                                     logic [PAY_W-1:0] payload, int fill, logic last);
    result_t r;
    r.status  = status;
    r.key     = key;
    r.payload = payload;
    r.fill    = fill[FILL_W-1:0];
    r.last    = last;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted command to the shadow queue and queue up its results
  function automatic void apply_command(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                        logic [PAY_W-1:0] payload, logic recovery);
    int   w;
    int   n;
    bit   removed;
    logic [STAT_W-1:0] st;
    case (mode)
      MODE_PUSH: begin
        if (recovery) begin
          // head insert, no coalescing
          if (held_count >= QDEPTH) begin
            st = STAT_DROPPED;
          end else begin
            for (int i = held_count; i > 0; i--) begin
              held_key[i] = held_key[i-1];
              held_pay[i] = held_pay[i-1];
            end
            held_key[0] = key;
            held_pay[0] = payload;
            held_count++;
            st = STAT_QUEUED;
          end
        end else begin
          // drop every entry with this key, keep the rest in order
          w = 0;
          removed = 1'b0;
          for (int i = 0; i < held_count; i++) begin
            if (held_key[i] == key) begin
              removed = 1'b1;
            end else begin
              held_key[w] = held_key[i];
              held_pay[w] = held_pay[i];
              w++;
            end
          end
          held_count = w;
          if (!removed && held_count >= QDEPTH) begin
            st = STAT_DROPPED;
          end else begin
            held_key[held_count] = key;
            held_pay[held_count] = payload;
            held_count++;
            st = removed ? STAT_COALESCED : STAT_QUEUED;
          end
        end
        add_result(st, '0, '0, held_count, 1'b1);
      end
      MODE_POP: begin
        if (held_count == 0) begin
          add_result(STAT_EMPTY, '0, '0, 0, 1'b1);
        end else begin
          add_result(STAT_POPPED, held_key[0], held_pay[0], held_count - 1, 1'b1);
          for (int i = 1; i < held_count; i++) begin
            held_key[i-1] = held_key[i];
            held_pay[i-1] = held_pay[i];
          end
          held_count--;
        end
      end
      MODE_FLUSH: begin
        if (held_count == 0) begin
          add_result(STAT_EMPTY, '0, '0, 0, 1'b1);
        end else begin
          n = held_count;
          for (int i = 0; i < n; i++)
            add_result(STAT_FLUSHED, held_key[i], held_pay[i], n - 1 - i, i == n - 1);
          held_count = 0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Track accepted commands and check every result transfer
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        apply_command(s_tuser[1:0], s_tdata[7:0], s_tdata[23:8], s_tuser[2]);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d key %0h",
                   $time, m_tuser, m_tdata[7:0]);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(m_tuser));
          check_field("out_key", 32'(want.key), 32'(m_tdata[7:0]));
          check_field("out_payload", 32'(want.payload), 32'(m_tdata[23:8]));
          check_field("fill_level", 32'(want.fill), 32'(m_tdata[28:24]));
          check_field("last", 32'(want.last), 32'(m_tlast));
        end
      end
    end
  end

  // Hang detection
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Send one command; called and returns at a falling edge, tvalid left high
  task automatic send_cmd(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                          logic [PAY_W-1:0] payload, logic recovery);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {payload, key};
    s_tuser  <= {recovery, mode};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic test_empty_queue();
    send_cmd(MODE_POP, 8'h00, 16'h0000, 1'b0);
    send_cmd(MODE_FLUSH, 8'hFF, 16'hFFFF, 1'b1);
    send_cmd(MODE_UNUSED, 8'h3C, 16'hA5A5, 1'b1);
  endtask

  task automatic test_coalescing();
    send_cmd(MODE_PUSH, 8'h00, 16'h0000, 1'b0);
    send_cmd(MODE_PUSH, 8'hFF, 16'hFFFF, 1'b0);
    send_cmd(MODE_PUSH, 8'h00, 16'h1234, 1'b0);   // replaces the first entry
    // recovery pushes never coalesce, so the same key can be held twice
    send_cmd(MODE_PUSH, 8'h55, 16'h0055, 1'b1);
    send_cmd(MODE_PUSH, 8'h55, 16'h00AA, 1'b1);
    send_cmd(MODE_PUSH, 8'h55, 16'hBEEF, 1'b0);   // removes both copies
    send_cmd(MODE_POP, 8'h00, 16'h0000, 1'b0);
    send_cmd(MODE_FLUSH, 8'h00, 16'h0000, 1'b0);
  endtask

  task automatic test_full_queue();
    // fill the queue with one key through the head
    for (int i = 0; i < QDEPTH; i++)
      send_cmd(MODE_PUSH, 8'hAA, 16'(i), 1'b1);
    send_cmd(MODE_PUSH, 8'h01, 16'h0101, 1'b0);   // new key, no room
    send_cmd(MODE_PUSH, 8'h02, 16'h0202, 1'b1);   // recovery on full
    send_cmd(MODE_PUSH, 8'hAA, 16'hCAFE, 1'b0);   // clears every entry, then appends
    send_cmd(MODE_PUSH, 8'hAB, 16'h7777, 1'b1);
    send_cmd(MODE_FLUSH, 8'h00, 16'h0000, 1'b0);
  endtask

  task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
    int sent;
    int r;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 70)      mode = MODE_PUSH;
      else if (r < 92) mode = MODE_POP;
      else if (r < 97) mode = MODE_FLUSH;
      else             mode = MODE_UNUSED;
      // mostly a small key pool so that pushes collide
      key = ($urandom_range(3) != 0) ? 8'($urandom_range(23)) : 8'($urandom_range(255));
      send_cmd(mode, key, 16'($urandom_range(16'hFFFF)), $urandom_range(4) == 0);
      if (mode != MODE_UNUSED)
        sent++;
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_coalescing();
    test_full_queue();
    test_random_traffic(32, 0, 0);
    test_random_traffic(32, 64, 0);
    test_random_traffic(32, 0, 64);
    test_random_traffic(32, 7, 7);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* coalescing_command_queue_unit.f */
+incdir+src
src/ccq_pkg.sv
src/ccq_cell.sv
src/coalescing_command_queue_unit.sv
tb/tb.sv
